/* rtl/sida_pkg.sv */
// Package for the signed integer to decimal ASCII formatter.
// Holds the widths, character codes, the bus between digit cells and the power-of-ten helpers.
// No dependencies.
package sida_pkg;

    // Number of decimal positions examined, from 10^(DIGIT_POSITIONS-1) down to 10^0.
    localparam int DIGIT_POSITIONS = 10;

    localparam int MAG_W  = 32;
    localparam int CHAR_W = 7;
    localparam int DIG_W  = 4;
    localparam int DIGV_W = DIG_W * DIGIT_POSITIONS;
    localparam int POS_W  = (DIGIT_POSITIONS > 1) ? $clog2(DIGIT_POSITIONS) : 1;
    localparam int NDIG_W = $clog2(DIGIT_POSITIONS + 1);

    localparam logic [CHAR_W-1:0] CH_ZERO  = 7'h30;
    localparam logic [CHAR_W-1:0] CH_MINUS = 7'h2D;
    localparam logic [DIG_W-1:0]  DIGIT_MAX = 4'd9;

    // Power of ten for constant expressions, evaluated at elaboration.
    function automatic logic [63:0] pow10_const(input int k);
        logic [63:0] w;
        w = 64'd1;
        for (int i = 0; i < k; i++) begin
            w = w * 64'd10;
        end
        return w;
    endfunction

    // Largest magnitude that the positions can show: all nines.
    localparam logic [63:0] MAG_LIMIT = pow10_const(DIGIT_POSITIONS) - 64'd1;

    // Power of ten selected by a position signal: a small constant table.
    function automatic logic [63:0] pow10_sel(input logic [4:0] k);
        logic [63:0] w;
        case (k)
            5'd0:    w = 64'd1;
            5'd1:    w = 64'd10;
            5'd2:    w = 64'd100;
            5'd3:    w = 64'd1000;
            5'd4:    w = 64'd10000;
            5'd5:    w = 64'd100000;
            5'd6:    w = 64'd1000000;
            5'd7:    w = 64'd10000000;
            5'd8:    w = 64'd100000000;
            5'd9:    w = 64'd1000000000;
            5'd10:   w = 64'd10000000000;
            5'd11:   w = 64'd100000000000;
            5'd12:   w = 64'd1000000000000;
            5'd13:   w = 64'd10000000000000;
            5'd14:   w = 64'd100000000000000;
            5'd15:   w = 64'd1000000000000000;
            5'd16:   w = 64'd10000000000000000;
            5'd17:   w = 64'd100000000000000000;
            5'd18:   w = 64'd1000000000000000000;
            default: w = 64'd1;
        endcase
        return w;
    endfunction

    // What one digit cell hands to the next one.
    typedef struct packed {
        logic                                 valid;
        logic                                 neg;
        logic [MAG_W-1:0]                     rem;
        logic [DIGIT_POSITIONS-1:0][DIG_W-1:0] digits;
        logic                                 started;
        logic [NDIG_W-1:0]                    ndig;
        logic [POS_W-1:0]                     pos;
    } t_cell_bus;

endpackage

/* rtl/sida_cell.sv */
// One digit cell of the formatter chain: extracts one decimal digit of the remainder.
// Depends on sida_pkg.
module sida_cell (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_adv,
    input  sida_pkg::t_cell_bus  i_bus,
    output sida_pkg::t_cell_bus  o_bus
);

    sida_pkg::t_cell_bus  r_bus;
    sida_pkg::t_cell_bus  n_bus;
    logic [63:0]          weight;
    logic [63:0]          thr [0:9];
    logic [3:0]           dig;
    logic [63:0]          rem_ext;

    always_comb begin
        weight  = sida_pkg::pow10_sel(5'(i_bus.pos));
        rem_ext = 64'(i_bus.rem);
        thr[0]  = 64'd0;
        for (int d = 1; d < 10; d++) begin
            thr[d] = weight * 64'(d);
        end
        // Thresholds rise with d, so the highest one passed is the digit.
        dig = 4'd0;
        for (int d = 1; d < 10; d++) begin
            if (rem_ext >= thr[d]) begin
                dig = 4'(d);
            end
        end
        if (dig > sida_pkg::DIGIT_MAX) begin
            dig = sida_pkg::DIGIT_MAX;
        end

        n_bus         = i_bus;
        n_bus.rem     = i_bus.rem - thr[dig][sida_pkg::MAG_W-1:0];
        n_bus.digits  = (i_bus.digits << sida_pkg::DIG_W) | sida_pkg::DIGV_W'(dig);
        n_bus.started = i_bus.started | (dig != 4'd0);
        n_bus.ndig    = i_bus.ndig + sida_pkg::NDIG_W'(n_bus.started);
        n_bus.pos     = i_bus.pos - sida_pkg::POS_W'(1);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bus.valid <= 1'b0;
        end else if (i_adv) begin
            r_bus <= n_bus;
        end
    end

    assign o_bus = r_bus;

endmodule

/* rtl/sida_serializer.sv */
// Output serializer: sends the sign and the significant digits one character per transaction.
// Depends on sida_pkg.
module sida_serializer (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  sida_pkg::t_cell_bus           i_bus,
    output logic                          o_load_ok,
    output logic                          o_valid,
    input  logic                          i_ready,
    output logic [sida_pkg::CHAR_W-1:0]   o_char,
    output logic                          o_last
);

    logic                                                    r_busy;
    logic                                                    r_neg;
    logic [sida_pkg::NDIG_W-1:0]                             r_cnt;
    logic [sida_pkg::DIGIT_POSITIONS-1:0][sida_pkg::DIG_W-1:0] r_digits;
    logic                                                    xfer;
    logic                                                    load;
    logic [sida_pkg::POS_W-1:0]                              idx;

    assign xfer      = r_busy & i_ready;
    assign o_last    = !r_neg && (r_cnt == sida_pkg::NDIG_W'(1));
    assign o_load_ok = !r_busy || (xfer && o_last);
    assign load      = i_bus.valid && o_load_ok;
    assign idx       = sida_pkg::POS_W'(r_cnt - sida_pkg::NDIG_W'(1));
    assign o_valid   = r_busy;
    assign o_char    = r_neg ? sida_pkg::CH_MINUS
                             : sida_pkg::CH_ZERO + sida_pkg::CHAR_W'(r_digits[idx]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_neg  <= 1'b0;
            r_cnt  <= '0;
        end else if (load) begin
            r_busy   <= 1'b1;
            r_neg    <= i_bus.neg;
            // A zero value has no significant digit and still shows one '0'.
            r_cnt    <= (i_bus.ndig == '0) ? sida_pkg::NDIG_W'(1) : i_bus.ndig;
            r_digits <= i_bus.digits;
        end else if (xfer) begin
            if (o_last) begin
                r_busy <= 1'b0;
            end else if (r_neg) begin
                r_neg <= 1'b0;
            end else begin
                r_cnt <= r_cnt - sida_pkg::NDIG_W'(1);
            end
        end
    end

endmodule

/* rtl/signed_int_to_decimal_ascii.sv */
// Top level of the signed integer to decimal ASCII formatter.
// Depends on sida_pkg, sida_cell and sida_serializer.
//
//  Channel  | Direction | tdata (lowest bit up)       | tlast
//  s_axis   | in        | number[31:0], signed        | -
//  m_axis   | out       | ascii_char[6:0], zero bit 7 | last_char
//
// Each number passes an input register and a row of DIGIT_POSITIONS digit cells, then
// waits in the serializer. The serializer sends one character per cycle while the
// receiver is ready, so a number takes 1 to 11 characters of output (sign plus
// significant digits); the output byte rate sets the throughput. While one number is
// being sent, later numbers advance through the cells. When the output stalls and the
// last cell holds a number, the whole row holds. Reset clears the valid flags and the
// serializer's busy flag, sign and count; no state is kept between numbers.
module signed_int_to_decimal_ascii (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,   // [31:0] number
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [7:0]  m_axis_tdata,   // [6:0] ascii_char, [7] zero
    output logic        m_axis_tlast    // last_char
);

    localparam int P = sida_pkg::DIGIT_POSITIONS;

    // Chain of buses: entry 0 is the input register, entry k+1 is the output of cell k.
    sida_pkg::t_cell_bus              chain [0:P];
    logic                             adv;
    logic                             load_ok;
    logic                             r_fvalid;
    logic                             r_fneg;
    logic [sida_pkg::MAG_W-1:0]       r_fmag;
    logic [sida_pkg::MAG_W-1:0]       n_fmag;
    logic [sida_pkg::CHAR_W-1:0]      out_char;

    // The row moves whenever the last cell is empty or its number goes into the serializer.
    assign adv           = !chain[P].valid || load_ok;
    assign s_axis_tready = adv;

    // Magnitude in unsigned arithmetic, so the most negative value keeps all its digits;
    // a magnitude beyond what the positions can show saturates to all nines.
    always_comb begin
        n_fmag = s_axis_tdata[31] ? (~s_axis_tdata + 32'd1) : s_axis_tdata;
        if (64'(n_fmag) > sida_pkg::MAG_LIMIT) begin
            n_fmag = sida_pkg::MAG_LIMIT[sida_pkg::MAG_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fvalid <= 1'b0;
        end else if (adv) begin
            r_fvalid <= s_axis_tvalid;
            r_fneg   <= s_axis_tdata[31];
            r_fmag   <= n_fmag;
        end
    end

    always_comb begin
        chain[0]         = '0;
        chain[0].valid   = r_fvalid;
        chain[0].neg     = r_fneg;
        chain[0].rem     = r_fmag;
        chain[0].started = 1'b0;
        chain[0].ndig    = '0;
        chain[0].pos     = sida_pkg::POS_W'(P - 1);
    end

    for (genvar k = 0; k < P; k++) begin : g_cell
        sida_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_adv   (adv),
            .i_bus   (chain[k]),
            .o_bus   (chain[k+1])
        );
    end

    sida_serializer u_ser (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_bus     (chain[P]),
        .o_load_ok (load_ok),
        .o_valid   (m_axis_tvalid),
        .i_ready   (m_axis_tready),
        .o_char    (out_char),
        .o_last    (m_axis_tlast)
    );

    assign m_axis_tdata = {1'b0, out_char};

endmodule

/* rtl/sida_checker.sv */
// Port-level checks for the signed integer to decimal ASCII formatter, bound to the top.
// Depends only on the top level's ports.
module sida_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic [31:0] s_axis_tdata,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [7:0]  m_axis_tdata,
    input logic        m_axis_tlast
);

    // A stalled output transaction keeps its character and its end flag.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast))
        else $error("output changed while stalled");

    // Only a minus sign or a decimal digit is ever sent.
    a_char_set: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |->
            (m_axis_tdata == 8'h2D) || (m_axis_tdata >= 8'h30 && m_axis_tdata <= 8'h39))
        else $error("character outside the decimal set");

    // A sign never ends a run.
    a_sign_not_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tdata == 8'h2D |-> !m_axis_tlast)
        else $error("run ends on a sign");

    // A digit is offered at once after a sign has been sent.
    a_digit_after_sign: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tready && m_axis_tdata == 8'h2D |=>
            m_axis_tvalid && m_axis_tdata != 8'h2D)
        else $error("no digit follows a sign");

    // The first digit after a sign is never a zero.
    a_no_leading_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tready && m_axis_tdata == 8'h2D |=>
            m_axis_tdata != 8'h30)
        else $error("leading zero after a sign");

endmodule

bind signed_int_to_decimal_ascii sida_checker u_sida_checker (.*);

/* sim/signed_int_to_decimal_ascii_tb.sv */
// Testbench for the signed integer to decimal ASCII formatter.
// Predicts the character run of every accepted number and checks each output transaction.
// Depends on sida_pkg and the RTL top level signed_int_to_decimal_ascii.
module signed_int_to_decimal_ascii_tb;

    // A generous ceiling: about 500 numbers of up to 11 characters each, with the receiver
    // stalling most of the time in one phase, stay well below this.
    localparam int CYCLE_LIMIT = 400000;

    // One character of a formatted number, as the output channel should carry it.
    typedef struct packed {
        logic [sida_pkg::CHAR_W-1:0] code;
        logic                        last;
    } t_text_char;

    logic        i_clk;
    logic        i_rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [31:0] s_axis_tdata;   // [31:0] number
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [7:0]  m_axis_tdata;   // [6:0] ascii_char, [7] zero
    logic        m_axis_tlast;   // last_char

    // Characters still owed by the block, oldest first.
    t_text_char pending_text[$];

    int cycle_count    = 0;
    int mismatch_count = 0;
    int chars_seen     = 0;

    // Idle percentages for the sending and receiving sides; changed between phases.
    int send_idle_pct = 0;
    int recv_idle_pct = 0;

    signed_int_to_decimal_ascii dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    initial begin
        i_clk = 1'b0;
        forever begin
            #4 i_clk = ~i_clk;
        end
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
    end

    // Watchdog: a hung handshake ends the run as a failure.
    initial begin
        wait (cycle_count >= CYCLE_LIMIT);
        $display("Timeout after %0d cycles, %0d characters outstanding",
                 cycle_count, pending_text.size());
        $display("Regression FAIL");
        $finish;
    end

    task automatic report_mismatch(input string what);
        $display("ERROR cycle %0d: %s", cycle_count, what);
        mismatch_count++;
    endtask

    // Works out the decimal text of one number and appends it to the pending characters.
    // The magnitude is taken in unsigned arithmetic so that the most negative value keeps
    // its full ten digits; a magnitude wider than the digit positions saturates to all
    // nines, and a run never exceeds eleven characters.
    function automatic void predict_decimal_text(input logic [31:0] number);
        logic [63:0] magnitude;
        logic [63:0] weight;
        logic [63:0] ceiling;
        logic [63:0] digit;
        logic        negative;
        logic        started;
        t_text_char  run[$];
        t_text_char  one_char;

        negative  = number[31];
        magnitude = {32'd0, negative ? (~number + 32'd1) : number};
        weight    = 64'd1;
        started   = 1'b0;
        for (int p = 1; p < sida_pkg::DIGIT_POSITIONS; p++) begin
            weight = weight * 64'd10;
        end
        ceiling = weight * 64'd10 - 64'd1;
        if (magnitude > ceiling) begin
            magnitude = ceiling;
        end

        if (negative) begin
            one_char.code = sida_pkg::CH_MINUS;
            one_char.last = 1'b0;
            run.push_back(one_char);
        end

        for (int p = 0; p < sida_pkg::DIGIT_POSITIONS; p++) begin
            digit     = magnitude / weight;
            magnitude = magnitude % weight;
            if (digit > 64'(sida_pkg::DIGIT_MAX)) begin
                digit = 64'(sida_pkg::DIGIT_MAX);
            end
            if (digit != 64'd0) begin
                started = 1'b1;
            end
            if (started && run.size() < 11) begin
                one_char.code = sida_pkg::CH_ZERO + sida_pkg::CHAR_W'(digit);
                one_char.last = 1'b0;
                run.push_back(one_char);
            end
            weight = weight / 64'd10;
        end

        // Zero prints as a lone '0' with no sign.
        if (!started) begin
            one_char.code = sida_pkg::CH_ZERO;
            one_char.last = 1'b0;
            run.push_back(one_char);
        end

        run[run.size() - 1].last = 1'b1;
        foreach (run[i]) begin
            pending_text.push_back(run[i]);
        end
    endfunction

    // Offers one number on the input channel and waits for the transaction to complete.
    // An optional idle gap comes first; tvalid stays high across back-to-back numbers.
    task automatic send_number(input logic [31:0] number);
        while ($urandom_range(99) < send_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            s_axis_tdata  <= $urandom();
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= number;
        @(posedge i_clk);
        while (s_axis_tready !== 1'b1) begin
            @(posedge i_clk);
        end
        predict_decimal_text(number);
    endtask

    // Random value with exactly the given count of decimal digits and the given sign.
    function automatic logic [31:0] number_of_length(input int digits, input logic negative);
        logic [63:0] lowest;
        logic [63:0] highest;
        logic [63:0] magnitude;

        lowest = 64'd1;
        for (int i = 1; i < digits; i++) begin
            lowest = lowest * 64'd10;
        end
        highest = (digits == 1) ? 64'd9 : lowest * 64'd10 - 64'd1;
        if (digits == 1) begin
            lowest = 64'd1;
        end
        if (!negative && highest > 64'h7FFF_FFFF) begin
            highest = 64'h7FFF_FFFF;
        end
        if (negative && highest > 64'h8000_0000) begin
            highest = 64'h8000_0000;
        end
        magnitude = lowest + ({$urandom(), $urandom()} % (highest - lowest + 64'd1));
        return negative ? (~magnitude[31:0] + 32'd1) : magnitude[31:0];
    endfunction

    // Mixed random stimulus: raw 32-bit patterns, numbers of every length, values around
    // powers of ten, small values near zero, and values near both ends of the range.
    function automatic logic [31:0] random_number();
        int          pick;
        logic [63:0] power;
        logic [31:0] value;

        pick = $urandom_range(9);
        case (pick)
            0, 1, 2, 3: begin
                value = $urandom();
            end
            4, 5, 6: begin
                value = number_of_length($urandom_range(1, 10), 1'($urandom_range(1)));
            end
            7: begin
                power = 64'd1;
                repeat ($urandom_range(9)) power = power * 64'd10;
                value = power[31:0] + 32'($urandom_range(2)) - 32'd1;
                if ($urandom_range(1) == 1) begin
                    value = ~value + 32'd1;
                end
            end
            8: begin
                value = 32'($urandom_range(40)) - 32'd20;
            end
            default: begin
                if ($urandom_range(1) == 1) begin
                    value = 32'h8000_0000 + 32'($urandom_range(3));
                end else begin
                    value = 32'h7FFF_FFFF - 32'($urandom_range(3));
                end
            end
        endcase
        return value;
    endfunction

    // Directed values: zero, single digits, the extremes of the range, every digit value,
    // zeros inside a number, and the boundaries between lengths.
    task automatic test_directed_values();
        logic [31:0] values[$];

        values = '{32'd0, 32'd1, 32'hFFFF_FFFF, 32'd9, -32'sd9, 32'd10, -32'sd10,
                   32'd99, 32'd100, 32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0001,
                   32'd1000000000, 32'd999999999, -32'sd1000000000, 32'd1234567890,
                   -32'sd1234567890, 32'd1000000007, 32'd2000000000, -32'sd2000000001,
                   32'd1286608618, 32'd1010101010};
        foreach (values[i]) begin
            send_number(values[i]);
        end
    endtask

    // One number of every length from one to ten digits, with each sign.
    task automatic test_every_length();
        for (int digits = 1; digits <= 10; digits++) begin
            send_number(number_of_length(digits, 1'b0));
            send_number(number_of_length(digits, 1'b1));
        end
    endtask

    task automatic test_random_numbers(input int count);
        repeat (count) send_number(random_number());
    endtask

    // Receiver: accepts characters under random back-pressure and checks each one
    // against the oldest pending character, field by field.
    initial begin
        t_text_char want;

        m_axis_tready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n === 1'b1 && m_axis_tvalid === 1'b1 && m_axis_tready === 1'b1) begin
                chars_seen++;
                if (pending_text.size() == 0) begin
                    report_mismatch($sformatf("unexpected character 0x%02h last %b",
                                              m_axis_tdata, m_axis_tlast));
                end else begin
                    want = pending_text.pop_front();
                    if (m_axis_tdata[sida_pkg::CHAR_W-1:0] !== want.code) begin
                        report_mismatch($sformatf("character %0d: ascii_char 0x%02h, want 0x%02h",
                                                  chars_seen,
                                                  m_axis_tdata[sida_pkg::CHAR_W-1:0],
                                                  want.code));
                    end
                    if (m_axis_tlast !== want.last) begin
                        report_mismatch($sformatf("character %0d: last_char %b, want %b",
                                                  chars_seen, m_axis_tlast, want.last));
                    end
                    if (m_axis_tdata[7:sida_pkg::CHAR_W] !== '0) begin
                        report_mismatch($sformatf("character %0d: padding bit is %b",
                                                  chars_seen,
                                                  m_axis_tdata[7:sida_pkg::CHAR_W]));
                    end
                end
            end
            m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    initial begin
        i_rst_n       <= 1'b0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // First phase: the sender idles lightly while the receiver stalls often.
        send_idle_pct = 16;
        recv_idle_pct = 69;
        test_directed_values();
        test_every_length();
        test_random_numbers(160);

        // Second phase: the sender idles often, the receiver rarely.
        send_idle_pct = 69;
        recv_idle_pct = 16;
        test_random_numbers(150);

        // Third phase: back-to-back transactions on both sides.
        send_idle_pct = 0;
        recv_idle_pct = 0;
        test_random_numbers(150);

        s_axis_tvalid <= 1'b0;
        while (pending_text.size() != 0) begin
            @(posedge i_clk);
        end
        // Let any stray character that the pipeline might still hold come out.
        repeat (sida_pkg::DIGIT_POSITIONS + 16) @(posedge i_clk);

        if (mismatch_count == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
